/* hdl/lhhb_pkg.sv */
`timescale 1ns / 1ps

package lhhb_pkg;

  // session states
  typedef enum logic [1:0] {
    LINK_DISC = 2'd0,
    LINK_WAIT = 2'd1,
    LINK_CONN = 2'd2
  } link_state_t;

  // request codes
  typedef enum logic [3:0] {
    REQ_CONNECT   = 4'd0,
    REQ_HANDSHAKE = 4'd1,
    REQ_TEXT      = 4'd2,
    REQ_ACK       = 4'd3,
    REQ_PING      = 4'd4,
    REQ_PONG      = 4'd5,
    REQ_TICK      = 4'd6,
    REQ_LINK_ERR  = 4'd7,
    REQ_LOCAL_DISC = 4'd8,
    REQ_SEND      = 4'd9
  } req_t;

  // action codes
  typedef enum logic [3:0] {
    ACT_STATE      = 4'd0,
    ACT_SEND_HS    = 4'd1,
    ACT_SEND_ACK   = 4'd2,
    ACT_SEND_PONG  = 4'd3,
    ACT_SEND_PING  = 4'd4,
    ACT_DELIVER    = 4'd5,
    ACT_REPORT_ACK = 4'd6,
    ACT_SEND_TEXT  = 4'd7,
    ACT_REFUSED    = 4'd8,
    ACT_NOTICE     = 4'd9
  } action_t;

  // disconnect reasons
  typedef enum logic [1:0] {
    RSN_NONE       = 2'd0,
    RSN_LINK_ERROR = 2'd1,
    RSN_HS_TIMEOUT = 2'd2,
    RSN_HB_TIMEOUT = 2'd3
  } reason_t;

  // one result beat
  typedef struct packed {
    action_t     action;
    logic [31:0] msg_id;
    link_state_t link_state;
    reason_t     reason;
  } beat_t;

  // register map, word index
  typedef enum logic [1:0] {
    REG_HS_TIMEOUT   = 2'd0,
    REG_PING_INTERVAL = 2'd1,
    REG_PONG_TIMEOUT = 2'd2
  } reg_idx_t;

  localparam int unsigned TimerWidth = 16;
  localparam int unsigned MaxBeats   = 3;
  localparam int unsigned CntWidth   = $clog2(MaxBeats + 1);

  localparam logic [TimerWidth-1:0] HsTimeoutReset   = 16'd10;
  localparam logic [TimerWidth-1:0] PingIntervalReset = 16'd30;
  localparam logic [TimerWidth-1:0] PongTimeoutReset = 16'd10;

  // a zero setting still arms the timer so it fires on the next tick
  function automatic logic [TimerWidth-1:0] arm_count(input logic [TimerWidth-1:0] v);
    return (v == '0) ? TimerWidth'(1) : v;
  endfunction

  function automatic beat_t mk_beat(input action_t act, input logic [31:0] id,
                                    input link_state_t st, input reason_t rsn);
    beat_t b;
    b.action     = act;
    b.msg_id     = id;
    b.link_state = st;
    b.reason     = rsn;
    return b;
  endfunction

endpackage

/* hdl/link_handshake_heartbeat_fsm_unit.sv */
`timescale 1ns / 1ps

// Link-session controller with heartbeat supervision. The session moves
// between disconnected, awaiting handshake and connected; each request beat
// (connect, handshake, text, ack, ping, pong, tick, link error, local
// disconnect, send request) is decoded combinationally against the
// session state and the three tick timers, and produces zero to three result
// beats that go into a three-entry result buffer, the final one flagged by
// last. Rate: a request is taken every cycle as long as the result buffer is
// empty or holds only one beat that is leaving in this cycle; the buffer
// drains one beat per cycle unless the receiver stalls, so a request with
// several result beats holds off the next until they drain, and requests with
// zero or one result run at one per cycle. Requests that do nothing in the
// current state (and unknown codes 10 to 15) give no result beat. The three
// timeout registers sit on an APB port at byte addresses 0, 4 and 8 and are
// meant to be written only while the block is idle.
module link_handshake_heartbeat_fsm_unit
  import lhhb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [3:0]  req_type,
  input  logic        initiator,
  input  logic [31:0] msg_id,
  // result channel
  output logic        res_valid,
  input  logic        res_stall,
  output logic [3:0]  action,
  output logic [31:0] msg_id_res,
  output logic [1:0]  link_state,
  output logic [1:0]  disconnect_reason,
  output logic        last,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration registers
  logic [TimerWidth-1:0] hs_timeout;
  logic [TimerWidth-1:0] ping_interval;
  logic [TimerWidth-1:0] pong_timeout;

  // session state and timers
  link_state_t           session_state, session_state_next;
  logic                  initiator_flag, initiator_flag_next;
  logic [TimerWidth-1:0] hs_left, hs_left_next;
  logic [TimerWidth-1:0] ping_left, ping_left_next;
  logic [TimerWidth-1:0] pong_left, pong_left_next;

  // result buffer, slot 0 is the head
  beat_t                beats [MaxBeats];
  logic [CntWidth-1:0]  beat_cnt;

  beat_t                new_beats [MaxBeats];
  logic [CntWidth-1:0]  new_cnt;

  logic accept, pop, cfg_write;
  logic hs_fire, ping_fire, pong_fire;
  logic [TimerWidth-1:0] hs_dec, ping_dec, pong_dec;
  beat_t idle_beat;

  // ------------------------------------------------------------------
  // configuration port
  // ------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hs_timeout    <= HsTimeoutReset;
      ping_interval <= PingIntervalReset;
      pong_timeout  <= PongTimeoutReset;
    end else if (cfg_write) begin
      unique case (reg_idx_t'(paddr[3:2]))
        REG_HS_TIMEOUT:    hs_timeout    <= pwdata[TimerWidth-1:0];
        REG_PING_INTERVAL: ping_interval <= pwdata[TimerWidth-1:0];
        REG_PONG_TIMEOUT:  pong_timeout  <= pwdata[TimerWidth-1:0];
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_HS_TIMEOUT:    prdata = {16'd0, hs_timeout};
      REG_PING_INTERVAL: prdata = {16'd0, ping_interval};
      REG_PONG_TIMEOUT:  prdata = {16'd0, pong_timeout};
      default:           prdata = 32'd0;
    endcase
  end

  // ------------------------------------------------------------------
  // handshakes
  // ------------------------------------------------------------------
  // a new request may enter once the buffer holds at most the beat that
  // is leaving in this cycle
  assign req_stall = (beat_cnt > CntWidth'(1)) ||
                     ((beat_cnt == CntWidth'(1)) && res_stall);
  assign accept    = req_valid && !req_stall;
  assign res_valid = (beat_cnt != '0);
  assign pop       = res_valid && !res_stall;

  // ------------------------------------------------------------------
  // timers: an armed timer counts down per tick and fires on reaching zero
  // ------------------------------------------------------------------
  assign hs_fire   = (hs_left == TimerWidth'(1));
  assign ping_fire = (ping_left == TimerWidth'(1));
  assign pong_fire = (pong_left == TimerWidth'(1));
  assign hs_dec    = (hs_left != '0) ? hs_left - TimerWidth'(1) : hs_left;
  assign ping_dec  = (ping_left != '0) ? ping_left - TimerWidth'(1) : ping_left;
  assign pong_dec  = (pong_left != '0) ? pong_left - TimerWidth'(1) : pong_left;

  assign idle_beat = mk_beat(ACT_STATE, 32'd0, LINK_DISC, RSN_NONE);

  // ------------------------------------------------------------------
  // session decode: next state and the result beats of this request
  // ------------------------------------------------------------------
  always_comb begin
    session_state_next  = session_state;
    initiator_flag_next = initiator_flag;
    hs_left_next        = hs_left;
    ping_left_next      = ping_left;
    pong_left_next      = pong_left;
    new_beats[0]        = idle_beat;
    new_beats[1]        = idle_beat;
    new_beats[2]        = idle_beat;
    new_cnt             = '0;

    unique case (req_t'(req_type))
      REQ_CONNECT: begin
        // tear down an existing session without a notice, then wait for handshake
        initiator_flag_next = initiator;
        session_state_next  = LINK_WAIT;
        hs_left_next        = arm_count(hs_timeout);
        ping_left_next      = '0;
        pong_left_next      = '0;
        if (session_state != LINK_DISC) begin
          new_beats[0] = mk_beat(ACT_STATE, 32'd0, LINK_DISC, RSN_NONE);
          new_beats[1] = mk_beat(ACT_STATE, 32'd0, LINK_WAIT, RSN_NONE);
          new_beats[2] = mk_beat(ACT_SEND_HS, 32'd0, LINK_WAIT, RSN_NONE);
          new_cnt      = initiator ? CntWidth'(3) : CntWidth'(2);
        end else begin
          new_beats[0] = mk_beat(ACT_STATE, 32'd0, LINK_WAIT, RSN_NONE);
          new_beats[1] = mk_beat(ACT_SEND_HS, 32'd0, LINK_WAIT, RSN_NONE);
          new_cnt      = initiator ? CntWidth'(2) : CntWidth'(1);
        end
      end
      REQ_HANDSHAKE: begin
        if (session_state == LINK_WAIT) begin
          session_state_next = LINK_CONN;
          hs_left_next       = '0;
          ping_left_next     = arm_count(ping_interval);
          // the responder answers with its own handshake first
          if (!initiator_flag) begin
            new_beats[0] = mk_beat(ACT_SEND_HS, 32'd0, LINK_WAIT, RSN_NONE);
            new_beats[1] = mk_beat(ACT_STATE, 32'd0, LINK_CONN, RSN_NONE);
            new_cnt      = CntWidth'(2);
          end else begin
            new_beats[0] = mk_beat(ACT_STATE, 32'd0, LINK_CONN, RSN_NONE);
            new_cnt      = CntWidth'(1);
          end
        end
      end
      REQ_TEXT: begin
        if (session_state == LINK_CONN) begin
          new_beats[0] = mk_beat(ACT_SEND_ACK, msg_id, LINK_CONN, RSN_NONE);
          new_beats[1] = mk_beat(ACT_DELIVER, msg_id, LINK_CONN, RSN_NONE);
          new_cnt      = CntWidth'(2);
        end
      end
      REQ_ACK: begin
        if (session_state == LINK_CONN) begin
          new_beats[0] = mk_beat(ACT_REPORT_ACK, msg_id, LINK_CONN, RSN_NONE);
          new_cnt      = CntWidth'(1);
        end
      end
      REQ_PING: begin
        if (session_state == LINK_CONN) begin
          new_beats[0] = mk_beat(ACT_SEND_PONG, 32'd0, LINK_CONN, RSN_NONE);
          new_cnt      = CntWidth'(1);
        end
      end
      REQ_PONG: begin
        if (session_state == LINK_CONN) begin
          pong_left_next = '0;
        end
      end
      REQ_TICK: begin
        if (hs_fire && (session_state == LINK_WAIT)) begin
          // handshake never arrived
          session_state_next = LINK_DISC;
          hs_left_next       = '0;
          ping_left_next     = '0;
          pong_left_next     = '0;
          new_beats[0] = mk_beat(ACT_STATE, 32'd0, LINK_DISC, RSN_NONE);
          new_beats[1] = mk_beat(ACT_NOTICE, 32'd0, LINK_DISC, RSN_HS_TIMEOUT);
          new_cnt      = CntWidth'(2);
        end else if (pong_fire && (session_state == LINK_CONN)) begin
          // missed pong wins over a ping due on the same tick
          session_state_next = LINK_DISC;
          hs_left_next       = '0;
          ping_left_next     = '0;
          pong_left_next     = '0;
          new_beats[0] = mk_beat(ACT_STATE, 32'd0, LINK_DISC, RSN_NONE);
          new_beats[1] = mk_beat(ACT_NOTICE, 32'd0, LINK_DISC, RSN_HB_TIMEOUT);
          new_cnt      = CntWidth'(2);
        end else if (ping_fire && (session_state == LINK_CONN)) begin
          hs_left_next   = hs_dec;
          ping_left_next = arm_count(ping_interval);
          pong_left_next = arm_count(pong_timeout);
          new_beats[0]   = mk_beat(ACT_SEND_PING, 32'd0, LINK_CONN, RSN_NONE);
          new_cnt        = CntWidth'(1);
        end else begin
          hs_left_next   = hs_dec;
          ping_left_next = ping_dec;
          pong_left_next = pong_dec;
        end
      end
      REQ_LINK_ERR: begin
        hs_left_next   = '0;
        ping_left_next = '0;
        pong_left_next = '0;
        if (session_state != LINK_DISC) begin
          session_state_next = LINK_DISC;
          new_beats[0] = mk_beat(ACT_STATE, 32'd0, LINK_DISC, RSN_NONE);
          new_beats[1] = mk_beat(ACT_NOTICE, 32'd0, LINK_DISC, RSN_LINK_ERROR);
          new_cnt      = CntWidth'(2);
        end
      end
      REQ_LOCAL_DISC: begin
        hs_left_next   = '0;
        ping_left_next = '0;
        pong_left_next = '0;
        if (session_state != LINK_DISC) begin
          session_state_next = LINK_DISC;
          new_beats[0] = mk_beat(ACT_STATE, 32'd0, LINK_DISC, RSN_NONE);
          new_cnt      = CntWidth'(1);
        end
      end
      REQ_SEND: begin
        new_beats[0] = mk_beat((session_state == LINK_CONN) ? ACT_SEND_TEXT : ACT_REFUSED,
                               32'd0, session_state, RSN_NONE);
        new_cnt      = CntWidth'(1);
      end
      default: ;  // unknown request codes are ignored
    endcase
  end

  // session state register
  always_ff @(posedge clk) begin
    if (rst) begin
      session_state  <= LINK_DISC;
      initiator_flag <= 1'b0;
      hs_left        <= '0;
      ping_left      <= '0;
      pong_left      <= '0;
    end else if (accept) begin
      session_state  <= session_state_next;
      initiator_flag <= initiator_flag_next;
      hs_left        <= hs_left_next;
      ping_left      <= ping_left_next;
      pong_left      <= pong_left_next;
    end
  end

  // ------------------------------------------------------------------
  // result buffer: loads a whole request's beats, shifts out one per pop
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      beat_cnt <= '0;
    end else if (accept) begin
      beat_cnt <= new_cnt;
    end else if (pop) begin
      beat_cnt <= beat_cnt - CntWidth'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      beats[0] <= new_beats[0];
      beats[1] <= new_beats[1];
      beats[2] <= new_beats[2];
    end else if (pop) begin
      beats[0] <= beats[1];
      beats[1] <= beats[2];
    end
  end

  assign action            = beats[0].action;
  assign msg_id_res        = beats[0].msg_id;
  assign link_state        = beats[0].link_state;
  assign disconnect_reason = beats[0].reason;
  assign last              = (beat_cnt == CntWidth'(1));

endmodule

/* test/link_handshake_heartbeat_fsm_unit_test.sv */
`timescale 1ns / 1ps

module link_handshake_heartbeat_fsm_unit_test
  import lhhb_pkg::*;
();

  // longest run of cycles with no beat on either channel before giving up
  localparam int WatchdogLimit = 2000;
  // receiver hold-off long enough to fill the three-entry result buffer
  localparam int HoldOffCycles = 80;
  // cycles allowed for an event with no result to clear the pipeline
  localparam int SettleCycles  = 6;
  localparam int MaxPrinted    = 40;

  // one expected result beat
  typedef struct packed {
    action_t     action;
    logic [31:0] msg_id;
    link_state_t state;
    reason_t     reason;
    logic        last;
  } link_action_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic [3:0]  req_type = '0;
  logic        initiator = 1'b0;
  logic [31:0] msg_id = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic [3:0]  action;
  logic [31:0] msg_id_res;
  logic [1:0]  link_state;
  logic [1:0]  disconnect_reason;
  logic        last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  link_handshake_heartbeat_fsm_unit i_dut (
    .clk               (clk),
    .rst               (rst),
    .req_valid         (req_valid),
    .req_stall         (req_stall),
    .req_type          (req_type),
    .initiator         (initiator),
    .msg_id            (msg_id),
    .res_valid         (res_valid),
    .res_stall         (res_stall),
    .action            (action),
    .msg_id_res        (msg_id_res),
    .link_state        (link_state),
    .disconnect_reason (disconnect_reason),
    .last              (last),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  initial begin
    forever begin
      #10 clk = ~clk;
    end
  end

  // session predictor state, mirrors the block after every accepted beat
  link_state_t     sess_state = LINK_DISC;
  logic            initiator_flag = 1'b0;
  logic [15:0]     hs_left = '0;
  logic [15:0]     ping_left = '0;
  logic [15:0]     pong_left = '0;
  logic [15:0]     hs_timeout_cfg = 16'd10;
  logic [15:0]     ping_interval_cfg = 16'd30;
  logic [15:0]     pong_timeout_cfg = 16'd10;
  bit              event_effective;

  link_action_t    expected_actions_q[$];
  link_action_t    want;
  int              mismatches = 0;
  int              quiet_cycles = 0;

  // idling control shared by both sides, and the receiver hold-off request
  bit              idle_enable = 1'b1;
  bit              hold_request = 1'b0;
  int              hold_left = 0;

  task automatic report_mismatch(input string what);
    if (mismatches < MaxPrinted) begin
      $display("mismatch at %0t: %s", $realtime, what);
    end
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // a zero setting still gives one tick
  function automatic logic [15:0] arm_ticks(input logic [15:0] v);
    return (v == '0) ? 16'd1 : v;
  endfunction

  function automatic void push_action(input action_t a, input logic [31:0] id,
                                      input reason_t r);
    link_action_t item;
    item.action = a;
    item.msg_id = id;
    item.state  = sess_state;
    item.reason = r;
    item.last   = 1'b0;
    expected_actions_q.push_back(item);
  endfunction

  // a state change beat only when the state really moves
  function automatic void move_state(input link_state_t s);
    if (sess_state != s) begin
      sess_state = s;
      push_action(ACT_STATE, '0, RSN_NONE);
    end
  endfunction

  function automatic void drop_session();
    hs_left   = '0;
    ping_left = '0;
    pong_left = '0;
    move_state(LINK_DISC);
  endfunction

  // teardown with a notice, only when there was a session to lose
  function automatic void fail_session(input reason_t r);
    link_state_t was;
    was = sess_state;
    drop_session();
    if (was != LINK_DISC) begin
      push_action(ACT_NOTICE, '0, r);
    end
  endfunction

  function automatic void predict_link_event(input logic [3:0] code, input logic init,
                                             input logic [31:0] id);
    int           first;
    logic         conn;
    logic         hs_fire;
    logic         ping_fire;
    logic         pong_fire;
    link_action_t tail;
    first = expected_actions_q.size();
    conn = (sess_state == LINK_CONN);
    event_effective = 1'b1;
    case (code)
      REQ_CONNECT: begin
        if (sess_state != LINK_DISC) begin
          drop_session();
        end
        initiator_flag = init;
        move_state(LINK_WAIT);
        if (init) begin
          push_action(ACT_SEND_HS, '0, RSN_NONE);
        end
        hs_left   = arm_ticks(hs_timeout_cfg);
        ping_left = '0;
        pong_left = '0;
      end
      REQ_HANDSHAKE: begin
        if (sess_state == LINK_WAIT) begin
          hs_left = '0;
          if (!initiator_flag) begin
            push_action(ACT_SEND_HS, '0, RSN_NONE);
          end
          move_state(LINK_CONN);
          ping_left = arm_ticks(ping_interval_cfg);
        end else begin
          event_effective = 1'b0;
        end
      end
      REQ_TEXT: begin
        if (conn) begin
          push_action(ACT_SEND_ACK, id, RSN_NONE);
          push_action(ACT_DELIVER, id, RSN_NONE);
        end else begin
          event_effective = 1'b0;
        end
      end
      REQ_ACK: begin
        if (conn) begin
          push_action(ACT_REPORT_ACK, id, RSN_NONE);
        end else begin
          event_effective = 1'b0;
        end
      end
      REQ_PING: begin
        if (conn) begin
          push_action(ACT_SEND_PONG, '0, RSN_NONE);
        end else begin
          event_effective = 1'b0;
        end
      end
      REQ_PONG: begin
        if (conn) begin
          pong_left = '0;
        end else begin
          event_effective = 1'b0;
        end
      end
      REQ_TICK: begin
        // armed counters step down, firing on the step that reaches zero
        hs_fire   = (hs_left == 16'd1);
        ping_fire = (ping_left == 16'd1);
        pong_fire = (pong_left == 16'd1);
        if (hs_left != '0) begin
          hs_left--;
        end
        if (ping_left != '0) begin
          ping_left--;
        end
        if (pong_left != '0) begin
          pong_left--;
        end
        if (hs_fire && sess_state == LINK_WAIT) begin
          fail_session(RSN_HS_TIMEOUT);
        end else if (conn && pong_fire) begin
          // missing pong wins over a ping due in the same tick
          fail_session(RSN_HB_TIMEOUT);
        end else if (conn && ping_fire) begin
          push_action(ACT_SEND_PING, '0, RSN_NONE);
          pong_left = arm_ticks(pong_timeout_cfg);
          ping_left = arm_ticks(ping_interval_cfg);
        end
      end
      REQ_LINK_ERR: begin
        if (sess_state == LINK_DISC) begin
          event_effective = 1'b0;
        end
        fail_session(RSN_LINK_ERROR);
      end
      REQ_LOCAL_DISC: begin
        if (sess_state == LINK_DISC) begin
          event_effective = 1'b0;
        end
        drop_session();
      end
      REQ_SEND: begin
        push_action(conn ? ACT_SEND_TEXT : ACT_REFUSED, '0, RSN_NONE);
      end
      default: begin
        event_effective = 1'b0;
      end
    endcase
    // flag the final beat of this event
    if (expected_actions_q.size() > first) begin
      tail = expected_actions_q[expected_actions_q.size() - 1];
      tail.last = 1'b1;
      expected_actions_q[expected_actions_q.size() - 1] = tail;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // channel drivers and result checker
  // ---------------------------------------------------------------------------

  // one request beat; valid stays high after acceptance so back-to-back beats
  // need no extra edge
  task automatic send_event(input logic [3:0] code, input logic init,
                            input logic [31:0] id);
    while (idle_enable && $urandom_range(99) < 29) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_type  <= code;
    initiator <= init;
    msg_id    <= id;
    do @(posedge clk); while (req_stall);
    predict_link_event(code, init, id);
  endtask

  // sender pauses until every pending beat is out, then lets the block settle
  task automatic wait_results_drained();
    req_valid <= 1'b0;
    while (expected_actions_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SettleCycles) @(posedge clk);
  endtask

  // write all three timeout registers, each followed by a readback
  task automatic set_timeouts(input logic [15:0] hs, input logic [15:0] ping,
                              input logic [15:0] pong);
    logic [15:0] vals [3];
    reg_idx_t    regs [3];
    vals[0] = hs;
    vals[1] = ping;
    vals[2] = pong;
    regs[0] = REG_HS_TIMEOUT;
    regs[1] = REG_PING_INTERVAL;
    regs[2] = REG_PONG_TIMEOUT;
    wait_results_drained();
    for (int i = 0; i < 3; i++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {regs[i], 2'b00};
      pwdata  <= {16'h0000, vals[i]};
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      // straight into the read setup phase
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      if (prdata[15:0] !== vals[i]) begin
        report_mismatch($sformatf("register %0d reads %h, wrote %h",
                                  i, prdata[15:0], vals[i]));
      end
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    hs_timeout_cfg    = hs;
    ping_interval_cfg = ping;
    pong_timeout_cfg  = pong;
  endtask

  // receiver: random stalls, or a counted hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        res_stall <= 1'b1;
        hold_left--;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HoldOffCycles - 1;
        res_stall <= 1'b1;
      end else begin
        res_stall <= idle_enable && ($urandom_range(99) < 29);
      end
    end
  end

  // every accepted result beat against the oldest pending one
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (expected_actions_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat, action %0d", action));
      end else begin
        want = expected_actions_q.pop_front();
        if (action !== want.action) begin
          report_mismatch($sformatf("action %0d, want %0d", action, want.action));
        end
        if (msg_id_res !== want.msg_id) begin
          report_mismatch($sformatf("msg_id_res %h, want %h", msg_id_res, want.msg_id));
        end
        if (link_state !== want.state) begin
          report_mismatch($sformatf("link_state %0d, want %0d", link_state, want.state));
        end
        if (disconnect_reason !== want.reason) begin
          report_mismatch($sformatf("disconnect_reason %0d, want %0d",
                                    disconnect_reason, want.reason));
        end
        if (last !== want.last) begin
          report_mismatch($sformatf("last %0b, want %0b", last, want.last));
        end
      end
    end
  end

  // watchdog on cycles with no beat moving on either channel
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (res_valid && !res_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("timeout: no beat for %0d cycles", WatchdogLimit);
        $display("status: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // every event in every state it matters in, reset timeouts
  task automatic test_each_event();
    // events while disconnected; all but send give no result beat
    send_event(REQ_SEND, 1'b0, '0);
    send_event(REQ_TEXT, 1'b0, 32'h1234_5678);
    send_event(REQ_HANDSHAKE, 1'b0, '0);
    send_event(REQ_PONG, 1'b0, '0);
    send_event(REQ_TICK, 1'b0, '0);
    send_event(REQ_LINK_ERR, 1'b0, '0);
    send_event(REQ_LOCAL_DISC, 1'b0, '0);
    send_event(4'd15, 1'b1, 32'hFFFF_FFFF);
    // initiator connect, then a second connect while awaiting
    send_event(REQ_CONNECT, 1'b1, '0);
    send_event(REQ_SEND, 1'b0, '0);
    send_event(REQ_CONNECT, 1'b0, '0);
    send_event(REQ_HANDSHAKE, 1'b0, '0);
    // connected traffic with extreme ids
    send_event(REQ_TEXT, 1'b0, 32'h0000_0000);
    send_event(REQ_TEXT, 1'b1, 32'hFFFF_FFFF);
    send_event(REQ_ACK, 1'b0, 32'hFFFF_FFFF);
    send_event(REQ_ACK, 1'b1, 32'h0000_0000);
    send_event(REQ_PING, 1'b0, '0);
    send_event(REQ_PONG, 1'b0, '0);
    send_event(REQ_SEND, 1'b0, '0);
    send_event(REQ_TICK, 1'b0, '0);
    send_event(4'd10, 1'b0, 32'hA5A5_5A5A);
    // reconnect from connected, link error while awaiting, local disconnect
    send_event(REQ_CONNECT, 1'b1, '0);
    send_event(REQ_LINK_ERR, 1'b0, '0);
    send_event(REQ_CONNECT, 1'b0, '0);
    send_event(REQ_LOCAL_DISC, 1'b0, '0);
  endtask

  task automatic test_timer_expiry();
    // handshake never comes
    set_timeouts(16'd2, 16'd1, 16'd1);
    send_event(REQ_CONNECT, 1'b0, '0);
    send_event(REQ_TICK, 1'b0, '0);
    send_event(REQ_TICK, 1'b0, '0);
    // pong expiry and ping due in the same tick: heartbeat timeout wins
    send_event(REQ_CONNECT, 1'b1, '0);
    send_event(REQ_HANDSHAKE, 1'b0, '0);
    send_event(REQ_TICK, 1'b0, '0);
    send_event(REQ_TICK, 1'b0, '0);
    // zero settings behave like one
    set_timeouts(16'd0, 16'd0, 16'd0);
    send_event(REQ_CONNECT, 1'b0, '0);
    send_event(REQ_TICK, 1'b0, '0);
    send_event(REQ_CONNECT, 1'b0, '0);
    send_event(REQ_HANDSHAKE, 1'b0, '0);
    send_event(REQ_TICK, 1'b0, '0);
    send_event(REQ_PONG, 1'b0, '0);
    send_event(REQ_TICK, 1'b0, '0);
    send_event(REQ_TICK, 1'b0, '0);
    // back-to-back pings re-arm a pong timer that is still running
    set_timeouts(16'd1, 16'd1, 16'd3);
    send_event(REQ_CONNECT, 1'b1, '0);
    send_event(REQ_HANDSHAKE, 1'b0, '0);
    send_event(REQ_TICK, 1'b0, '0);
    send_event(REQ_TICK, 1'b0, '0);
    send_event(REQ_TICK, 1'b0, '0);
    send_event(REQ_PONG, 1'b0, '0);
    send_event(REQ_LOCAL_DISC, 1'b0, '0);
  endtask

  // receiver holds off while text and send events keep coming
  task automatic test_result_holdoff();
    set_timeouts(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_event(REQ_CONNECT, 1'b1, '0);
    send_event(REQ_HANDSHAKE, 1'b0, '0);
    wait_results_drained();
    hold_request = 1'b1;
    for (int i = 0; i < 16; i++) begin
      send_event((i % 4 == 3) ? REQ_SEND : REQ_TEXT, 1'($urandom_range(1)), $urandom);
    end
    send_event(REQ_TICK, 1'b0, '0);
    send_event(REQ_LINK_ERR, 1'b0, '0);
    wait_results_drained();
  endtask

  // mostly well-formed sessions with random content, plus noise
  task automatic run_random_sessions(input int count);
    int          done;
    int          pick;
    logic [3:0]  code;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(99);
      code = 4'($urandom_range(15));
      case (sess_state)
        LINK_DISC: begin
          if (pick < 70) begin
            code = REQ_CONNECT;
          end
        end
        LINK_WAIT: begin
          if (pick < 55) begin
            code = REQ_HANDSHAKE;
          end else if (pick < 80) begin
            code = REQ_TICK;
          end else if (pick < 85) begin
            code = REQ_CONNECT;
          end
        end
        default: begin
          if (pick < 20) begin
            code = REQ_TEXT;
          end else if (pick < 32) begin
            code = REQ_ACK;
          end else if (pick < 42) begin
            code = REQ_PING;
          end else if (pick < 52) begin
            code = REQ_PONG;
          end else if (pick < 75) begin
            code = REQ_TICK;
          end else if (pick < 85) begin
            code = REQ_SEND;
          end else if (pick < 89) begin
            code = REQ_LINK_ERR;
          end else if (pick < 92) begin
            code = REQ_LOCAL_DISC;
          end else if (pick < 94) begin
            code = REQ_CONNECT;
          end
        end
      endcase
      send_event(code, 1'($urandom_range(1)), $urandom);
      if (event_effective) begin
        done++;
      end
    end
  endtask

  task automatic test_random_traffic();
    set_timeouts(16'd3, 16'd4, 16'd2);
    run_random_sessions(55);
    set_timeouts(16'd1, 16'd1, 16'd1);
    run_random_sessions(45);
    // stretch with no idling on either side
    set_timeouts(16'd5, 16'd3, 16'd3);
    idle_enable = 1'b0;
    run_random_sessions(55);
    wait_results_drained();
    idle_enable = 1'b1;
    set_timeouts(16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
                 16'($urandom_range(1, 6)));
    run_random_sessions(55);
    set_timeouts(16'hFFFF, 16'd2, 16'hFFFF);
    run_random_sessions(25);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_each_event();
    test_timer_expiry();
    test_result_holdoff();
    test_random_traffic();
    wait_results_drained();
    // extra cycles so a stray beat still shows up as unexpected
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/lhhb_pkg.sv
hdl/link_handshake_heartbeat_fsm_unit.sv
test/link_handshake_heartbeat_fsm_unit_test.sv
